>>> rtl/assert_macros.svh
// assertion helpers used by the matrix4x4_multiply_core rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> rtl/mm4_pkg.sv
`timescale 1ns / 1ps

package mm4_pkg;

  localparam int DIM_DEF   = 4;
  localparam int FRAC_DEF  = 16;
  localparam int ELEM_W    = 32;
  localparam int INDEX_W   = 4;

  // control flags that travel with one memory read pair down the pipeline
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mm4_tag_t;

endpackage

>>> rtl/mm4_store.sv
`timescale 1ns / 1ps

module mm4_store
  import mm4_pkg::*;
#(
  parameter int DIM = DIM_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          wr_en,
  input  logic [$clog2(DIM*DIM)-1:0]    wr_addr,
  input  logic [ELEM_W-1:0]             wr_a,
  input  logic [ELEM_W-1:0]             wr_b,
  input  logic [$clog2(DIM*DIM)-1:0]    rd_addr_a,
  input  logic [$clog2(DIM*DIM)-1:0]    rd_addr_b,
  input  mm4_tag_t                      rd_tag_in,
  input  logic [$clog2(DIM*DIM)-1:0]    rd_k_in,
  output mm4_tag_t                      rd_tag,
  output logic [$clog2(DIM*DIM)-1:0]    rd_k,
  output logic signed [ELEM_W-1:0]      rd_a,
  output logic signed [ELEM_W-1:0]      rd_b
);

  localparam int CELLS = DIM * DIM;

  logic [ELEM_W-1:0] left_mem  [CELLS];
  logic [ELEM_W-1:0] right_mem [CELLS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      left_mem[wr_addr]  <= wr_a;
      right_mem[wr_addr] <= wr_b;
    end
  end

  // registered read ports, held while the pipeline stalls
  always_ff @(posedge clk) begin
    if (en) begin
      rd_a <= left_mem[rd_addr_a];
      rd_b <= right_mem[rd_addr_b];
      rd_k <= rd_k_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_tag <= '0;
    end else if (en) begin
      rd_tag <= rd_tag_in;
    end
  end

endmodule

>>> rtl/mm4_mac.sv
`timescale 1ns / 1ps

module mm4_mac
  import mm4_pkg::*;
#(
  parameter int DIM       = DIM_DEF,
  parameter int FRAC_BITS = FRAC_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  mm4_tag_t                      tag,
  input  logic [$clog2(DIM*DIM)-1:0]    k,
  input  logic signed [ELEM_W-1:0]      a,
  input  logic signed [ELEM_W-1:0]      b,
  output logic                          m_tvalid,
  output logic [ELEM_W-1:0]             m_tdata,
  output logic [INDEX_W-1:0]            m_tuser,
  output logic                          m_tlast
);

  localparam int CELLS = DIM * DIM;
  localparam int KW    = $clog2(CELLS);
  localparam int PW    = 2 * ELEM_W;
  localparam int ACC_W = PW + $clog2(DIM) + 1;
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);
  localparam logic [KW-1:0] K_LAST = KW'(CELLS - 1);

  logic signed [PW-1:0]    prod;
  mm4_tag_t                tag2;
  logic [KW-1:0]           k2;
  logic signed [ACC_W-1:0] acc;
  logic                    done3;
  logic [KW-1:0]           k3;

  logic signed [ACC_W-1:0] biased;
  logic signed [ACC_W-1:0] shifted;
  logic                    in_range;
  logic [ELEM_W-1:0]       rounded;

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= a * b;
      k2   <= k;
    end
  end

  always_ff @(posedge clk) begin
    if (en && tag2.valid) begin
      if (tag2.first) begin
        acc <= ACC_W'(prod);
      end else begin
        acc <= acc + ACC_W'(prod);
      end
    end
    if (en) begin
      k3 <= k2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag2  <= '0;
      done3 <= 1'b0;
    end else if (en) begin
      tag2  <= tag;
      done3 <= tag2.valid && tag2.last;
    end
  end

  // round half up, then clamp to the 32-bit range
  always_comb begin
    biased   = acc + HALF;
    shifted  = biased >>> FRAC_BITS;
    in_range = (&shifted[ACC_W-1:ELEM_W-1]) || !(|shifted[ACC_W-1:ELEM_W-1]);
    if (in_range) begin
      rounded = shifted[ELEM_W-1:0];
    end else if (shifted[ACC_W-1]) begin
      rounded = {1'b1, {(ELEM_W-1){1'b0}}};
    end else begin
      rounded = {1'b0, {(ELEM_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= rounded;
      m_tuser <= INDEX_W'(k3);
      m_tlast <= (k3 == K_LAST);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= done3;
    end
  end

endmodule

>>> rtl/matrix4x4_multiply_core.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Streaming product R = A x B of two DIM x DIM signed fixed-point matrices,
// both column-major (index = column*DIM + row). Each input beat writes one
// element of A and the element of B at the same index into two small
// synchronous memories, one beat per cycle. After the last beat the block
// stops taking input and steps a single shared multiply-accumulator through
// DIM*DIM*DIM read pairs, one per cycle while the output is not stalled,
// limited by the one read port on each memory; read, multiply, accumulate
// and round/saturate are pipeline stages, and the DIM*DIM results leave in
// index order, tlast on the final one. Loading of the next pair starts as
// soon as the last read pair is issued, while results still drain. A stall
// on the output holds the whole compute pipeline in place.
module matrix4x4_multiply_core
  import mm4_pkg::*;
#(
  parameter int DIM       = DIM_DEF,
  parameter int FRAC_BITS = FRAC_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [63:0]          s_tdata,   // a_element [31:0], b_element [63:32]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [ELEM_W-1:0]    m_tdata,   // product_element [31:0]
  output logic [INDEX_W-1:0]   m_tuser,   // element_index [3:0]
  output logic                 m_tlast
);

  localparam int CELLS = DIM * DIM;
  localparam int AW    = $clog2(CELLS);
  localparam int JW    = $clog2(DIM);
  localparam logic [AW-1:0] DIM_A  = AW'(DIM);
  localparam logic [AW-1:0] C_LAST = AW'(CELLS - 1);
  localparam logic [JW-1:0] D_LAST = JW'(DIM - 1);

  typedef enum logic {
    ST_LOAD,
    ST_COMPUTE
  } state_t;

  state_t        state;
  logic [AW-1:0] load_count;
  logic [JW-1:0] row;
  logic [JW-1:0] col;
  logic [JW-1:0] j;
  logic [AW-1:0] k;

  logic          en;
  logic          wr_en;
  logic [AW-1:0] rd_addr_a;
  logic [AW-1:0] rd_addr_b;
  mm4_tag_t      iss_tag;
  mm4_tag_t      rd_tag;
  logic [AW-1:0] rd_k;
  logic signed [ELEM_W-1:0] rd_a;
  logic signed [ELEM_W-1:0] rd_b;

  assign s_tready = (state == ST_LOAD);
  assign wr_en    = s_tvalid && s_tready;
  assign en       = !m_tvalid || m_tready;

  // reads never overlap writes: loading waits until the last pair is issued
  assign rd_addr_a = AW'(AW'(j) * DIM_A + AW'(row));
  assign rd_addr_b = AW'(AW'(col) * DIM_A + AW'(j));

  assign iss_tag.valid = (state == ST_COMPUTE);
  assign iss_tag.first = (j == '0);
  assign iss_tag.last  = (j == D_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      load_count <= '0;
      row        <= '0;
      col        <= '0;
      j          <= '0;
      k          <= '0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (s_tvalid) begin
            if (load_count == C_LAST) begin
              load_count <= '0;
              state      <= ST_COMPUTE;
            end else begin
              load_count <= load_count + 1'b1;
            end
          end
        end
        ST_COMPUTE: begin
          if (en) begin
            if (j == D_LAST) begin
              j <= '0;
              if (k == C_LAST) begin
                k     <= '0;
                row   <= '0;
                col   <= '0;
                state <= ST_LOAD;
              end else begin
                k <= k + 1'b1;
                if (row == D_LAST) begin
                  row <= '0;
                  col <= col + 1'b1;
                end else begin
                  row <= row + 1'b1;
                end
              end
            end else begin
              j <= j + 1'b1;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  mm4_store #(
    .DIM(DIM)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .wr_en     (wr_en),
    .wr_addr   (load_count),
    .wr_a      (s_tdata[31:0]),
    .wr_b      (s_tdata[63:32]),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_tag_in (iss_tag),
    .rd_k_in   (k),
    .rd_tag    (rd_tag),
    .rd_k      (rd_k),
    .rd_a      (rd_a),
    .rd_b      (rd_b)
  );

  mm4_mac #(
    .DIM       (DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .tag      (rd_tag),
    .k        (rd_k),
    .a        (rd_a),
    .b        (rd_b),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  `ASSERT_IMPLIES(a_load_not_issuing, clk, rst, s_tvalid && s_tready, !iss_tag.valid)
  `ASSERT_IMPLIES(a_last_index, clk, rst, m_tvalid && m_tlast, m_tuser == INDEX_W'(CELLS - 1))
  `ASSERT_NEXT(a_issue_end, clk, rst, iss_tag.valid && iss_tag.last && en && k == C_LAST, s_tready)
  `ASSERT_NEXT(a_stall_hold, clk, rst, iss_tag.valid && !en, iss_tag.valid && $stable(j) && $stable(k))

endmodule

>>> verif/matrix4x4_multiply_core_tb.sv
`timescale 1ns / 1ps

module matrix4x4_multiply_core_tb;
  import mm4_pkg::*;

  localparam int CELLS           = DIM_DEF * DIM_DEF;
  localparam int RANDOM_MATRICES = 29;
  localparam int IDLE_LIMIT      = 3000;
  localparam int LONG_HOLD       = 400;
  localparam int DRAIN_CYCLES    = 40;

  localparam logic signed [71:0] Q_MAX    = 72'sh7FFF_FFFF;
  localparam logic signed [71:0] Q_MIN    = -72'sh8000_0000;
  localparam logic signed [71:0] HALF_LSB = 72'sd1 <<< (FRAC_DEF - 1);

  typedef struct {
    logic [ELEM_W-1:0] a;
    logic [ELEM_W-1:0] b;
    bit                drain_mark;  // sender waits here until all products are back
  } operand_beat_t;

  typedef struct {
    logic [ELEM_W-1:0]  value;
    logic [INDEX_W-1:0] idx;
    logic               last;
  } product_beat_t;

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [63:0]         s_tdata  = '0;   // a_element [31:0], b_element [63:32]
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [ELEM_W-1:0]   m_tdata;         // product_element [31:0]
  logic [INDEX_W-1:0]  m_tuser;         // element_index [3:0]
  logic                m_tlast;

  operand_beat_t stim_q[$];
  product_beat_t product_q[$];

  // predictor copy of the two operand matrices
  logic [ELEM_W-1:0] left_mat [CELLS];
  logic [ELEM_W-1:0] right_mat[CELLS];
  int                load_idx = 0;

  bit in_held   = 1'b0;
  bit timed_out = 1'b0;
  bit hold_done = 1'b0;
  int burst_left  = 1;
  int gap_left    = 0;
  int hold_left   = 0;
  int mode_left   = 0;
  int rx_mode     = 0;
  int rx_phase    = 0;
  int idle_cycles = 0;
  int beats_in    = 0;
  int beats_out   = 0;
  int matrices    = 0;
  int sat_hi      = 0;
  int sat_lo      = 0;
  int errors      = 0;

  always #10 clk = ~clk;

  matrix4x4_multiply_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  function automatic void push_beat(logic [ELEM_W-1:0] a, logic [ELEM_W-1:0] b);
    operand_beat_t beat;
    beat.a          = a;
    beat.b          = b;
    beat.drain_mark = 1'b0;
    stim_q.push_back(beat);
  endfunction

  function automatic void push_drain_mark();
    operand_beat_t beat;
    beat.a          = '0;
    beat.b          = '0;
    beat.drain_mark = 1'b1;
    stim_q.push_back(beat);
  endfunction

  function automatic logic [ELEM_W-1:0] pick_operand();
    logic [ELEM_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom;
      4, 5:       v = $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
      6, 7:       v = $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000;
      8: begin
        case ($urandom_range(0, 6))
          0:       v = 32'h8000_0000;
          1:       v = 32'h7FFF_FFFF;
          2:       v = 32'h0000_0000;
          3:       v = 32'h0000_0001;
          4:       v = 32'hFFFF_FFFF;
          5:       v = 32'h0001_0000;
          default: v = 32'hFFFF_0000;
        endcase
      end
      default: v = $urandom_range(0, 32'h7FFF_FFFF) | 32'h4000_0000 ^
                   ($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0);
    endcase
    return v;
  endfunction

  // store one operand pair; on the last index form all dot products
  task automatic load_operands(input logic [ELEM_W-1:0] a, input logic [ELEM_W-1:0] b);
    logic signed [71:0] acc;
    logic signed [71:0] shifted;
    logic signed [63:0] prod;
    product_beat_t      res;
    int                 col;
    int                 row;
    left_mat[load_idx]  = a;
    right_mat[load_idx] = b;
    load_idx++;
    if (load_idx == CELLS) begin
      load_idx = 0;
      matrices++;
      for (int k = 0; k < CELLS; k++) begin
        col = k / DIM_DEF;
        row = k % DIM_DEF;
        acc = '0;
        for (int j = 0; j < DIM_DEF; j++) begin
          prod = $signed(left_mat[j * DIM_DEF + row]) * $signed(right_mat[col * DIM_DEF + j]);
          acc  = acc + prod;
        end
        // round half up, then clamp to the 32-bit range
        shifted = (acc + HALF_LSB) >>> FRAC_DEF;
        if (shifted > Q_MAX) begin
          res.value = 32'h7FFF_FFFF;
          sat_hi++;
        end else if (shifted < Q_MIN) begin
          res.value = 32'h8000_0000;
          sat_lo++;
        end else begin
          res.value = shifted[31:0];
        end
        res.idx  = k[INDEX_W-1:0];
        res.last = (k == CELLS - 1);
        product_q.push_back(res);
      end
    end
  endtask

  // monitor: input accept feeds the predictor, output accept is checked
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (s_tvalid && s_tready) begin
        load_operands(s_tdata[31:0], s_tdata[63:32]);
        in_held     = 1'b0;
        beats_in++;
        idle_cycles = 0;
      end
      if (m_tvalid && m_tready) begin
        idle_cycles = 0;
        beats_out++;
        if (product_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected product beat value %h index %0d last %0b",
                   $time, m_tdata, m_tuser, m_tlast);
        end else begin
          product_beat_t want;
          want = product_q.pop_front();
          if ({m_tdata, m_tuser, m_tlast} !== {want.value, want.idx, want.last}) begin
            errors++;
            $display("%0t: product mismatch expected value %h index %0d last %0b, got value %h index %0d last %0b",
                     $time, want.value, want.idx, want.last, m_tdata, m_tuser, m_tlast);
          end
        end
      end
      if (idle_cycles >= IDLE_LIMIT) timed_out = 1'b1;
    end
  end

  // sender: bursts of beats separated by random gaps
  always @(negedge clk) begin
    operand_beat_t beat;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!in_held) begin
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (stim_q.size() == 0) begin
        s_tvalid <= 1'b0;
      end else if (stim_q[0].drain_mark) begin
        if (product_q.size() == 0) void'(stim_q.pop_front());
        s_tvalid <= 1'b0;
      end else begin
        beat = stim_q.pop_front();
        s_tdata  <= {beat.b, beat.a};
        s_tvalid <= 1'b1;
        in_held  = 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: gap_left = 0;
            9:             gap_left = $urandom_range(10, 40);
            default:       gap_left = $urandom_range(1, 6);
          endcase
        end else begin
          burst_left--;
        end
      end
    end
  end

  // receiver: stall pattern changes from stretch to stretch, plus one long hold
  always @(negedge clk) begin
    logic rdy;
    rdy = 1'b0;
    if (!rst) begin
      if (hold_left > 0) begin
        hold_left--;
      end else if (!hold_done && beats_out >= 3 * CELLS) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
        end else begin
          mode_left--;
        end
        case (rx_mode)
          0:       rdy = 1'b1;
          1:       rdy = 1'($urandom_range(0, 1));
          2:       rdy = ($urandom_range(0, 3) == 0);
          default: rdy = (rx_phase % 3 != 0);
        endcase
        rx_phase++;
      end
    end
    m_tready <= rdy;
  end

  initial begin
    logic [ELEM_W-1:0] tie_col[DIM_DEF];
    logic [ELEM_W-1:0] b;

    // left operand at the negative extreme: columns saturate high, low, zero, exact min
    for (int k = 0; k < CELLS; k++) begin
      case (k / DIM_DEF)
        0:       b = 32'h8000_0000;
        1:       b = 32'h7FFF_FFFF;
        2:       b = 32'h0000_0000;
        default: b = (k % DIM_DEF == 0) ? 32'h0001_0000 : 32'h0000_0000;
      endcase
      push_beat(32'h8000_0000, b);
    end
    // half-lsb ties in both signs and just below half
    tie_col[0] = 32'h0000_8000;
    tie_col[1] = 32'hFFFF_8000;
    tie_col[2] = 32'h0000_7FFF;
    tie_col[3] = 32'hFFFE_8000;
    for (int k = 0; k < CELLS; k++)
      push_beat(32'h0000_0001, (k % DIM_DEF == 0) ? tie_col[k / DIM_DEF] : 32'h0);
    push_drain_mark();

    for (int m = 0; m < RANDOM_MATRICES; m++) begin
      for (int k = 0; k < CELLS; k++) push_beat(pick_operand(), pick_operand());
      if (m == 10) push_drain_mark();
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (!((stim_q.size() == 0 && !in_held && product_q.size() == 0) || timed_out))
      @(posedge clk);

    if (timed_out) begin
      $display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
    end else begin
      repeat (DRAIN_CYCLES) @(posedge clk);
      if (product_q.size() != 0) errors++;
      $display("ran %0d matrix pairs: %0d operand beats in, %0d product beats checked",
               matrices, beats_in, beats_out);
      $display("saturated products: %0d high, %0d low; one long output stall, two drains",
               sat_hi, sat_lo);
      if (errors == 0) begin
        $display("Testbench completed without errors");
      end else begin
        $display("Testbench completed WITH ERRORS");
      end
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/mm4_pkg.sv
rtl/mm4_store.sv
rtl/mm4_mac.sv
rtl/matrix4x4_multiply_core.sv
verif/matrix4x4_multiply_core_tb.sv
